### design/spcr_pkg.sv
// ----------------------------------------------------------------------------
// spcr_pkg: shared types and constants of the switch panel change reporter
// Field widths, frame byte constants, angle scaling constants and the
// structures that pass between the front end, the frame queue and the back end.
// ----------------------------------------------------------------------------
package spcr_pkg;

    // Steering converter width and the fixed switch group widths.
    localparam int ADC_BITS   = 12;
    localparam int DEADBAND_W = 12;
    localparam int SPEED_W    = 5;
    localparam int MODE_PIN_W = 2;
    localparam int SHEAR_PIN_W = 2;
    localparam int LEVER_PIN_W = 4;
    localparam int STEER_PIN_W = 5;

    // Input stream packing, lowest field first, padded to whole bytes.
    localparam int SPEED_LSB  = 0;
    localparam int MODE_LSB   = SPEED_LSB + SPEED_W;
    localparam int SHEAR_LSB  = MODE_LSB + MODE_PIN_W;
    localparam int LEVER_LSB  = SHEAR_LSB + SHEAR_PIN_W;
    localparam int STEER_LSB  = LEVER_LSB + LEVER_PIN_W;
    localparam int ADC_LSB    = STEER_LSB + STEER_PIN_W;
    localparam int SCAN_BITS  = ADC_LSB + ADC_BITS;
    localparam int S_TDATA_W  = ((SCAN_BITS + 7) / 8) * 8;

    // Report frame framing bytes.
    localparam logic [7:0] FRAME_HEADER  = 8'hAA;
    localparam logic [7:0] FRAME_TRAILER = 8'hFF;
    localparam int FRAME_LEN = 8;
    localparam int BYTE_IDX_W = $clog2(FRAME_LEN);

    // Steering angle: sample * 181 / 4036, clamped to 180.
    localparam int ANGLE_W     = 8;
    localparam int ANGLE_MUL   = 181;
    localparam int ANGLE_DIV   = 4036;
    localparam int ANGLE_MAX   = 180;
    localparam int PROD_W      = ADC_BITS + 8;
    localparam int QUOT_W      = PROD_W - $clog2(ANGLE_DIV) + 1;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = RECIP_SHIFT - $clog2(ANGLE_DIV) + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((64'd1 << RECIP_SHIFT) / ANGLE_DIV);

    // Frame queue depth.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    // One scan as unpacked from the input stream.
    typedef struct packed {
        logic [ADC_BITS-1:0]    adc_sample;
        logic [STEER_PIN_W-1:0] steer_pins;
        logic [LEVER_PIN_W-1:0] lever_pins;
        logic [SHEAR_PIN_W-1:0] shear_pins;
        logic [MODE_PIN_W-1:0]  mode_pins;
        logic [SPEED_W-1:0]     speed_pins;
    } scan_t;

    // Values carried by one report frame plus the end-of-scan mark.
    typedef struct packed {
        logic               scan_last;
        logic [1:0]         shear;
        logic [2:0]         lever;
        logic [ANGLE_W-1:0] angle;
        logic [2:0]         steer_mode;
        logic [2:0]         speed;
        logic [1:0]         mode;
    } frame_desc_t;

    // Write side of the frame queue.
    typedef struct packed {
        logic        push;
        frame_desc_t desc;
    } fifo_wr_t;

    // Read side of the frame queue.
    typedef struct packed {
        logic        valid;
        frame_desc_t desc;
    } fifo_rd_t;

    // Lowest pressed (low) pin of a five-pin group gives 1..5, none gives 0.
    function automatic logic [2:0] lowest_pressed5(input logic [4:0] pins);
        logic [2:0] code;
        code = 3'd0;
        for (int i = 4; i >= 0; i--) begin
            if (!pins[i]) begin
                code = 3'(i + 1);
            end
        end
        return code;
    endfunction

    // Two-pin group: first pin gives 1, else second pin gives 3, else 2.
    function automatic logic [1:0] pair_code(input logic [1:0] pins);
        logic [1:0] code;
        if (!pins[0]) begin
            code = 2'd1;
        end else if (!pins[1]) begin
            code = 2'd3;
        end else begin
            code = 2'd2;
        end
        return code;
    endfunction

    // Lever: forward 1, reverse 2, right 4, left 3, in that priority.
    function automatic logic [2:0] lever_code(input logic [3:0] pins);
        logic [2:0] code;
        if (!pins[0]) begin
            code = 3'd1;
        end else if (!pins[1]) begin
            code = 3'd2;
        end else if (!pins[2]) begin
            code = 3'd4;
        end else if (!pins[3]) begin
            code = 3'd3;
        end else begin
            code = 3'd0;
        end
        return code;
    endfunction

endpackage

### design/spcr_front.sv
// ----------------------------------------------------------------------------
// spcr_front: scan intake and change detection
// Holds one scan in an input register, encodes the switch groups, runs the
// deadband test and angle scaling, and queues one frame per changed value.
// ----------------------------------------------------------------------------
module spcr_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                scan_valid,
    output logic                                scan_ready,
    input  spcr_pkg::scan_t                     scan,
    input  logic [spcr_pkg::DEADBAND_W-1:0]     deadband,
    output spcr_pkg::fifo_wr_t                  wr,
    input  logic                                fifo_full
);
    import spcr_pkg::*;

    localparam int CMP_W = (ADC_BITS > DEADBAND_W) ? ADC_BITS : DEADBAND_W;

    // Value groups in the order they are handled within a scan.
    localparam logic [2:0] GRP_SPEED = 3'd0;
    localparam logic [2:0] GRP_MODE  = 3'd1;
    localparam logic [2:0] GRP_SHEAR = 3'd2;
    localparam logic [2:0] GRP_LEVER = 3'd3;
    localparam logic [2:0] GRP_STEER = 3'd4;
    localparam logic [2:0] GRP_ANGLE = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [2:0]              group_reg;
    logic [5:0]              chg_reg;

    logic                    hold_valid_reg;
    scan_t                   hold_scan_reg;

    logic [2:0]              speed_reg;
    logic [1:0]              mode_reg;
    logic [1:0]              shear_reg;
    logic [2:0]              lever_reg;
    logic [2:0]              steer_reg;
    logic [ADC_BITS-1:0]     sample_reg;
    logic [ANGLE_W-1:0]      angle_reg;

    logic [2:0]              new_speed_reg;
    logic [1:0]              new_mode_reg;
    logic [1:0]              new_shear_reg;
    logic [2:0]              new_lever_reg;
    logic [2:0]              new_steer_reg;
    logic [ANGLE_W-1:0]      new_angle_reg;
    logic                    pass_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [QUOT_W-1:0]       quot_reg;

    logic                    take;
    logic [2:0]              c_speed;
    logic [1:0]              c_mode;
    logic [1:0]              c_shear;
    logic [2:0]              c_lever;
    logic [2:0]              c_steer;
    logic [ADC_BITS-1:0]     diff;
    logic                    pass;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [PROD_W-1:0]       rem;
    logic [QUOT_W-1:0]       quot_fix;
    logic [ANGLE_W-1:0]      angle_next;
    logic                    cur_chg;
    logic                    push;

    // The input register frees the stream while a scan is being handled.
    assign scan_ready = !hold_valid_reg;
    assign take = (state_reg == ST_IDLE) && hold_valid_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
        end else if (scan_valid && scan_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (take) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (scan_valid && scan_ready) begin
            hold_scan_reg <= scan;
        end
    end

    // Group encoding and deadband test on the held scan.
    always_comb begin
        c_speed = lowest_pressed5(hold_scan_reg.speed_pins);
        c_mode  = pair_code(hold_scan_reg.mode_pins);
        c_shear = pair_code(hold_scan_reg.shear_pins);
        c_lever = lever_code(hold_scan_reg.lever_pins);
        c_steer = lowest_pressed5(hold_scan_reg.steer_pins);
        if (hold_scan_reg.adc_sample >= sample_reg) begin
            diff = hold_scan_reg.adc_sample - sample_reg;
        end else begin
            diff = sample_reg - hold_scan_reg.adc_sample;
        end
        pass = CMP_W'(diff) > CMP_W'(deadband);
    end

    // Division by the scale constant: reciprocal estimate, then one correction.
    assign recip_prod = (PROD_W+RECIP_W)'(prod_reg) * (PROD_W+RECIP_W)'(RECIP);

    always_comb begin
        rem = prod_reg - PROD_W'(PROD_W'(quot_reg) * PROD_W'(ANGLE_DIV));
        if (rem >= PROD_W'(ANGLE_DIV)) begin
            quot_fix = quot_reg + QUOT_W'(1);
        end else begin
            quot_fix = quot_reg;
        end
        if (32'(quot_fix) > 32'(ANGLE_MAX)) begin
            angle_next = ANGLE_W'(ANGLE_MAX);
        end else begin
            angle_next = ANGLE_W'(quot_fix);
        end
    end

    // Frame push: values as they stand once the current group is updated.
    always_comb begin
        cur_chg = chg_reg[group_reg];
        push    = (state_reg == ST_EMIT) && cur_chg && !fifo_full;
        wr.push = push;
        wr.desc.speed      = (group_reg == GRP_SPEED) ? new_speed_reg : speed_reg;
        wr.desc.mode       = (group_reg == GRP_MODE)  ? new_mode_reg  : mode_reg;
        wr.desc.shear      = (group_reg == GRP_SHEAR) ? new_shear_reg : shear_reg;
        wr.desc.lever      = (group_reg == GRP_LEVER) ? new_lever_reg : lever_reg;
        wr.desc.steer_mode = (group_reg == GRP_STEER) ? new_steer_reg : steer_reg;
        wr.desc.angle      = (group_reg == GRP_ANGLE) ? new_angle_reg : angle_reg;
        // No later group changes when nothing above the current bit is set.
        wr.desc.scan_last  = ((chg_reg >> group_reg) == 6'd1);
    end

    // Scan sequencer and the stored values.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            group_reg     <= GRP_SPEED;
            chg_reg       <= '0;
            speed_reg     <= '0;
            mode_reg      <= '0;
            shear_reg     <= '0;
            lever_reg     <= '0;
            steer_reg     <= '0;
            sample_reg    <= '0;
            angle_reg     <= '0;
            new_speed_reg <= '0;
            new_mode_reg  <= '0;
            new_shear_reg <= '0;
            new_lever_reg <= '0;
            new_steer_reg <= '0;
            new_angle_reg <= '0;
            pass_reg      <= 1'b0;
            prod_reg      <= '0;
            quot_reg      <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        new_speed_reg <= c_speed;
                        new_mode_reg  <= c_mode;
                        new_shear_reg <= c_shear;
                        new_lever_reg <= c_lever;
                        new_steer_reg <= c_steer;
                        chg_reg[GRP_SPEED] <= (c_speed != speed_reg);
                        chg_reg[GRP_MODE]  <= (c_mode != mode_reg);
                        chg_reg[GRP_SHEAR] <= (c_shear != shear_reg);
                        chg_reg[GRP_LEVER] <= (c_lever != lever_reg);
                        chg_reg[GRP_STEER] <= (c_steer != steer_reg);
                        chg_reg[GRP_ANGLE] <= 1'b0;
                        pass_reg <= pass;
                        prod_reg <= PROD_W'(hold_scan_reg.adc_sample) * PROD_W'(ANGLE_MUL);
                        if (pass) begin
                            sample_reg <= hold_scan_reg.adc_sample;
                        end
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    quot_reg  <= QUOT_W'(recip_prod >> RECIP_SHIFT);
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    new_angle_reg      <= angle_next;
                    chg_reg[GRP_ANGLE] <= pass_reg && (angle_next != angle_reg);
                    group_reg          <= GRP_SPEED;
                    state_reg          <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (push) begin
                        case (group_reg)
                            GRP_SPEED: speed_reg <= new_speed_reg;
                            GRP_MODE:  mode_reg  <= new_mode_reg;
                            GRP_SHEAR: shear_reg <= new_shear_reg;
                            GRP_LEVER: lever_reg <= new_lever_reg;
                            GRP_STEER: steer_reg <= new_steer_reg;
                            GRP_ANGLE: angle_reg <= new_angle_reg;
                            default:   speed_reg <= speed_reg;
                        endcase
                    end
                    if (!(cur_chg && fifo_full)) begin
                        if (group_reg == GRP_ANGLE) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            group_reg <= group_reg + 3'd1;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### design/spcr_fifo.sv
// ----------------------------------------------------------------------------
// spcr_fifo: frame queue
// A short queue of frame descriptors between the front end and the byte
// serializer, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module spcr_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  spcr_pkg::fifo_wr_t wr,
    output logic               full,
    input  logic               pop,
    output spcr_pkg::fifo_rd_t rd
);
    import spcr_pkg::*;

    frame_desc_t             mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_PTR_W:0]     count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full     = (count_reg == (FIFO_PTR_W+1)'(FIFO_DEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.desc  = mem_reg[rd_ptr_reg];
    assign do_push  = wr.push && !full;
    assign do_pop   = pop && rd.valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + (FIFO_PTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - (FIFO_PTR_W+1)'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge clk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr.desc;
        end
    end

endmodule

### design/spcr_back.sv
// ----------------------------------------------------------------------------
// spcr_back: frame serializer
// Takes frame descriptors from the queue and sends each as eight bytes,
// one per cycle while m_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module spcr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  spcr_pkg::fifo_rd_t rd,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast,
    output logic [0:0]         m_tuser
);
    import spcr_pkg::*;

    logic                  busy_reg;
    frame_desc_t           desc_reg;
    logic [BYTE_IDX_W-1:0] idx_reg;
    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic                  out_end_reg;
    logic                  out_last_reg;

    logic [7:0]            frame_bytes [FRAME_LEN];
    logic                  load;
    logic                  final_byte;

    // Frame layout in transmit order.
    always_comb begin
        frame_bytes[0] = FRAME_HEADER;
        frame_bytes[1] = 8'(desc_reg.mode);
        frame_bytes[2] = 8'(desc_reg.speed);
        frame_bytes[3] = 8'(desc_reg.steer_mode);
        frame_bytes[4] = 8'(desc_reg.angle);
        frame_bytes[5] = 8'(desc_reg.lever);
        frame_bytes[6] = 8'(desc_reg.shear);
        frame_bytes[7] = FRAME_TRAILER;
    end

    assign load       = busy_reg && (!out_valid_reg || m_tready);
    assign final_byte = (idx_reg == BYTE_IDX_W'(FRAME_LEN - 1));
    // The next frame is fetched as the current one sends its trailer.
    assign pop        = !busy_reg || (load && final_byte);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            desc_reg      <= '0;
            out_byte_reg  <= '0;
            out_end_reg   <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            // Output register: load a byte, or clear once taken. The byte
            // index wraps back to zero as the trailer is loaded.
            if (load) begin
                out_valid_reg <= 1'b1;
                out_byte_reg  <= frame_bytes[idx_reg];
                out_end_reg   <= final_byte;
                out_last_reg  <= final_byte && desc_reg.scan_last;
                idx_reg       <= idx_reg + BYTE_IDX_W'(1);
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            // Descriptor register.
            if (pop) begin
                busy_reg <= rd.valid;
                if (rd.valid) begin
                    desc_reg <= rd.desc;
                end
            end
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_end_reg;
    assign m_tuser[0] = out_last_reg;

endmodule

### design/switch_panel_change_reporter.sv
// Flow: the front end takes a scan through intake, multiply, divide and six group
// steps and can hold the next scan in its input register meanwhile; each frame
// leaves as eight output bytes.
// Reset: rst_n low clears all stored switch codes, sample and angle to zero,
// sets deadband to 25, and empties the input register, queue and output stage.
// ----------------------------------------------------------------------------
// switch_panel_change_reporter: top level
// Unpacks scans from the input stream, holds the deadband register on the
// configuration port, and joins the front end, frame queue and serializer.
// ----------------------------------------------------------------------------
module switch_panel_change_reporter (
    input  logic                          clk,
    input  logic                          rst_n,
    // Scan stream. tdata from bit 0: speed_pins[4:0], mode_pins[6:5],
    // shear_pins[8:7], lever_pins[12:9], steer_pins[17:13], adc_sample[29:18].
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [spcr_pkg::S_TDATA_W-1:0] s_tdata,
    // Report byte stream. tdata: tx_byte[7:0]. tlast: frame_end.
    // tuser: last[0].
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,
    output logic                          m_tlast,
    output logic [0:0]                    m_tuser,
    // Configuration port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import spcr_pkg::*;

    localparam logic DEADBAND_ADDR = 1'b0;
    localparam logic [DEADBAND_W-1:0] DEADBAND_RESET = DEADBAND_W'(25);

    logic [DEADBAND_W-1:0] deadband_reg;
    scan_t                 scan;
    fifo_wr_t              fifo_wr;
    fifo_rd_t              fifo_rd;
    logic                  fifo_full;
    logic                  fifo_pop;
    logic                  cfg_write;

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            deadband_reg <= DEADBAND_RESET;
        end else if (cfg_write && (paddr[2] == DEADBAND_ADDR)) begin
            deadband_reg <= pwdata[DEADBAND_W-1:0];
        end
    end

    assign prdata = (paddr[2] == DEADBAND_ADDR) ? 32'(deadband_reg) : 32'd0;

    // Scan unpacking.
    always_comb begin
        scan.speed_pins = s_tdata[SPEED_LSB +: SPEED_W];
        scan.mode_pins  = s_tdata[MODE_LSB +: MODE_PIN_W];
        scan.shear_pins = s_tdata[SHEAR_LSB +: SHEAR_PIN_W];
        scan.lever_pins = s_tdata[LEVER_LSB +: LEVER_PIN_W];
        scan.steer_pins = s_tdata[STEER_LSB +: STEER_PIN_W];
        scan.adc_sample = s_tdata[ADC_LSB +: ADC_BITS];
    end

    spcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .scan_valid (s_tvalid),
        .scan_ready (s_tready),
        .scan       (scan),
        .deadband   (deadband_reg),
        .wr         (fifo_wr),
        .fifo_full  (fifo_full)
    );

    spcr_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (fifo_wr),
        .full  (fifo_full),
        .pop   (fifo_pop),
        .rd    (fifo_rd)
    );

    spcr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (fifo_rd),
        .pop      (fifo_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The end-of-scan mark only ever sits on a frame trailer.
    a_last_on_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == FRAME_TRAILER)))
        else $error("end-of-scan mark outside a frame trailer");

    // After a trailer transaction the next byte shown is a header.
    a_header_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (!m_tvalid || (m_tdata == FRAME_HEADER)))
        else $error("frame does not start with a header");

    // The front end never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_wr.push |-> !fifo_full)
        else $error("frame queue overflow");

    // A deadband write takes effect at the next cycle.
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && (paddr[2] == DEADBAND_ADDR)) |=>
            (deadband_reg == $past(pwdata[DEADBAND_W-1:0])))
        else $error("deadband write lost");

endmodule
